[rtl/tmcs_pkg.sv]
// shared widths, field offsets and constants of the mip chain storage size block
package tmcs_pkg;

   localparam int SIZE_BITS_DEFAULT = 32;

   localparam int DIM_W   = 16;
   localparam int MIPS_W  = 8;
   localparam int BPP_W   = 8;
   localparam int BLK_W   = 5;
   localparam int BYTES_W = 32;
   localparam int MINB_W  = 2 * BLK_W;
   localparam int DEND_W  = DIM_W + 1;

   // request tdata offsets
   localparam int REQ_WIDTH_LO  = 0;
   localparam int REQ_HEIGHT_LO = REQ_WIDTH_LO + DIM_W;
   localparam int REQ_DEPTH_LO  = REQ_HEIGHT_LO + DIM_W;
   localparam int REQ_MIPS_LO   = REQ_DEPTH_LO + DIM_W;
   localparam int REQ_BPP_LO    = REQ_MIPS_LO + MIPS_W;
   localparam int REQ_BLKW_LO   = REQ_BPP_LO + BPP_W;
   localparam int REQ_BLKH_LO   = REQ_BLKW_LO + BLK_W;
   localparam int REQ_MBX_LO    = REQ_BLKH_LO + BLK_W;
   localparam int REQ_MBY_LO    = REQ_MBX_LO + BLK_W;
   localparam int REQ_USED_W    = REQ_MBY_LO + BLK_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // response tdata offsets
   localparam int RSP_BYTES_LO  = 0;
   localparam int RSP_PW_LO     = RSP_BYTES_LO + BYTES_W;
   localparam int RSP_PH_LO     = RSP_PW_LO + DIM_W;
   localparam int RSP_DEPTH_LO  = RSP_PH_LO + DIM_W;
   localparam int RSP_MIPS_LO   = RSP_DEPTH_LO + DIM_W;
   localparam int RSP_USED_W    = RSP_MIPS_LO + MIPS_W;
   localparam int RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;

   // remainder unit: bits per cycle and cycles per operand
   localparam int MOD_STEPS  = 6;
   localparam int MOD_CYCLES = (DEND_W + MOD_STEPS - 1) / MOD_STEPS;
   localparam int MOD_PAD_W  = MOD_STEPS * MOD_CYCLES;
   localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

   localparam int CUBE_SIDES = 6;
   localparam int BYTE_SHIFT = 3;

endpackage

[rtl/texture_mip_chain_storage_size.sv]
// top level: storage size of a texture mip chain with a shared remainder unit and multiplier
//
// one request item describes a texture and its format blocks; one response item carries the
// total storage bytes, padded base width and height, clamped depth and clamped mip count
// request: req_tvalid/req_tready/req_tdata/req_tuser, item taken when valid and ready are high
// response: rsp_tvalid/rsp_tready/rsp_tdata, held until rsp_tready
// the base padding runs two remainders; every mip level then runs two more remainders,
// four passes through the multiplier and one accumulate, the mip count clamped to at least one
// every level goes through the single remainder unit and multiplier in turn, so one item
// is worked on at a time
// req_tready is high only while the sequencer is idle
// the response sits in its own register, so a new item is taken while it waits; if the
// receiver still stalls when the next result is done, the sequencer holds it until the
// response register frees
// reset is synchronous and clears the sequencer and the response valid; no clearing pass
module texture_mip_chain_storage_size #(
   parameter int SIZE_BITS = tmcs_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // base_width, base_height, base_depth, mip_count, bpp, block_w, block_h,
   // min_blocks_x, min_blocks_y
   input  logic [tmcs_pkg::REQ_TDATA_W-1:0] req_tdata,
   // is_cube
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // storage_bytes, padded_width, padded_height, clamped_depth, clamped_mips
   output logic [tmcs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int DIM_W     = tmcs_pkg::DIM_W;
   localparam int MIPS_W    = tmcs_pkg::MIPS_W;
   localparam int BPP_W     = tmcs_pkg::BPP_W;
   localparam int BLK_W     = tmcs_pkg::BLK_W;
   localparam int MINB_W    = tmcs_pkg::MINB_W;
   localparam int DEND_W    = tmcs_pkg::DEND_W;
   localparam int BYTES_W   = tmcs_pkg::BYTES_W;
   localparam int MOD_STEPS = tmcs_pkg::MOD_STEPS;
   localparam int MOD_PAD_W = tmcs_pkg::MOD_PAD_W;
   localparam int MOD_CNT_W = tmcs_pkg::MOD_CNT_W;
   localparam int PROD_W    = SIZE_BITS + DEND_W;
   localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(tmcs_pkg::MOD_CYCLES - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PAD_W,
      ST_PAD_H,
      ST_LVL_W,
      ST_LVL_H,
      ST_MUL_WH,
      ST_MUL_D,
      ST_MUL_BPP,
      ST_MUL_SIDES,
      ST_ACC,
      ST_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic [MOD_CNT_W-1:0]   mod_cnt_ff, mod_cnt_in;
   logic [BLK_W-1:0]       rem_ff, rem_in;

   logic [DIM_W-1:0]       bw_ff, bw_in, bh_ff, bh_in;
   logic [DIM_W-1:0]       depth_ff, depth_in;
   logic                   cube_ff, cube_in;
   logic [MIPS_W-1:0]      mips_ff, mips_in;
   logic [BPP_W-1:0]       bpp_ff, bpp_in;
   logic [BLK_W-1:0]       blkw_ff, blkw_in, blkh_ff, blkh_in;
   logic [MINB_W-1:0]      minw_ff, minw_in, minh_ff, minh_in;

   logic [DIM_W-1:0]       pw_ff, pw_in, ph_ff, ph_in;
   logic [DIM_W-1:0]       w_ff, w_in, h_ff, h_in, d_ff, d_in;
   logic [DEND_W-1:0]      lw_ff, lw_in, lh_ff, lh_in;
   logic [MIPS_W-1:0]      lvl_ff, lvl_in;
   logic [SIZE_BITS-1:0]   t_ff, t_in, total_ff, total_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTES_W-1:0]     out_bytes_ff, out_bytes_in;
   logic [DIM_W-1:0]       out_pw_ff, out_pw_in, out_ph_ff, out_ph_in;
   logic [DIM_W-1:0]       out_depth_ff, out_depth_in;
   logic [MIPS_W-1:0]      out_mips_ff, out_mips_in;

   logic [BLK_W-1:0]       req_blkw, req_blkh;
   logic [DEND_W-1:0]      dend;
   logic [MOD_PAD_W-1:0]   dend_pad;
   logic [MOD_STEPS-1:0]   chunk;
   logic [BLK_W-1:0]       blk_sel;
   logic [BLK_W-1:0]       rem_step;
   logic [BLK_W:0]         r6;
   logic [DEND_W-1:0]      up;
   logic [DIM_W-1:0]       up16;
   logic [SIZE_BITS-1:0]   mul_a;
   logic [DEND_W-1:0]      mul_b;
   logic [PROD_W-1:0]      prod;
   logic                   rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_mips_ff, out_depth_ff, out_ph_ff, out_pw_ff, out_bytes_ff};
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // zero block size counts as one
   always_comb begin
      req_blkw = req_tdata[tmcs_pkg::REQ_BLKW_LO +: BLK_W];
      req_blkh = req_tdata[tmcs_pkg::REQ_BLKH_LO +: BLK_W];
      if (req_blkw == '0) begin
         req_blkw = BLK_W'(1);
      end
      if (req_blkh == '0) begin
         req_blkh = BLK_W'(1);
      end
   end

   // remainder unit: value plus block minus one, modulo block, MOD_STEPS bits per cycle
   always_comb begin
      case (state_ff)
         ST_PAD_W: dend = DEND_W'(bw_ff) + DEND_W'(blkw_ff) - DEND_W'(1);
         ST_PAD_H: dend = DEND_W'(bh_ff) + DEND_W'(blkh_ff) - DEND_W'(1);
         ST_LVL_W: dend = DEND_W'(w_ff) + DEND_W'(blkw_ff) - DEND_W'(1);
         ST_LVL_H: dend = DEND_W'(h_ff) + DEND_W'(blkh_ff) - DEND_W'(1);
         default:  dend = '0;
      endcase
      blk_sel  = (state_ff == ST_PAD_W || state_ff == ST_LVL_W) ? blkw_ff : blkh_ff;
      dend_pad = MOD_PAD_W'(dend);
      chunk    = dend_pad[MOD_PAD_W - 1 - int'(mod_cnt_ff) * MOD_STEPS -: MOD_STEPS];
      rem_step = rem_ff;
      r6       = '0;
      for (int j = 0; j < MOD_STEPS; j++) begin
         r6 = {rem_step, chunk[MOD_STEPS-1-j]};
         if (r6 >= {1'b0, blk_sel}) begin
            r6 = r6 - {1'b0, blk_sel};
         end
         rem_step = r6[BLK_W-1:0];
      end
      up   = dend - DEND_W'(rem_step);
      up16 = up[DIM_W-1:0];
   end

   // shared multiplier
   always_comb begin
      case (state_ff)
         ST_MUL_WH: begin
            mul_a = SIZE_BITS'(lw_ff);
            mul_b = lh_ff;
         end
         ST_MUL_D: begin
            mul_a = t_ff;
            mul_b = DEND_W'(d_ff);
         end
         ST_MUL_BPP: begin
            mul_a = t_ff;
            mul_b = DEND_W'(bpp_ff);
         end
         ST_MUL_SIDES: begin
            mul_a = t_ff >> tmcs_pkg::BYTE_SHIFT;
            mul_b = cube_ff ? DEND_W'(tmcs_pkg::CUBE_SIDES) : DEND_W'(1);
         end
         default: begin
            mul_a = t_ff;
            mul_b = '0;
         end
      endcase
      prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_comb begin
      state_in     = state_ff;
      mod_cnt_in   = mod_cnt_ff;
      rem_in       = rem_ff;
      bw_in        = bw_ff;
      bh_in        = bh_ff;
      depth_in     = depth_ff;
      cube_in      = cube_ff;
      mips_in      = mips_ff;
      bpp_in       = bpp_ff;
      blkw_in      = blkw_ff;
      blkh_in      = blkh_ff;
      minw_in      = minw_ff;
      minh_in      = minh_ff;
      pw_in        = pw_ff;
      ph_in        = ph_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      d_in         = d_ff;
      lw_in        = lw_ff;
      lh_in        = lh_ff;
      lvl_in       = lvl_ff;
      t_in         = t_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff;
      out_bytes_in = out_bytes_ff;
      out_pw_in    = out_pw_ff;
      out_ph_in    = out_ph_ff;
      out_depth_in = out_depth_ff;
      out_mips_in  = out_mips_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               bw_in    = req_tdata[tmcs_pkg::REQ_WIDTH_LO +: DIM_W];
               bh_in    = req_tdata[tmcs_pkg::REQ_HEIGHT_LO +: DIM_W];
               depth_in = req_tdata[tmcs_pkg::REQ_DEPTH_LO +: DIM_W];
               if (depth_in == '0) begin
                  depth_in = DIM_W'(1);
               end
               mips_in = req_tdata[tmcs_pkg::REQ_MIPS_LO +: MIPS_W];
               if (mips_in == '0) begin
                  mips_in = MIPS_W'(1);
               end
               cube_in    = req_tuser;
               bpp_in     = req_tdata[tmcs_pkg::REQ_BPP_LO +: BPP_W];
               blkw_in    = req_blkw;
               blkh_in    = req_blkh;
               minw_in    = MINB_W'(req_blkw) * MINB_W'(req_tdata[tmcs_pkg::REQ_MBX_LO +: BLK_W]);
               minh_in    = MINB_W'(req_blkh) * MINB_W'(req_tdata[tmcs_pkg::REQ_MBY_LO +: BLK_W]);
               mod_cnt_in = '0;
               rem_in     = '0;
               state_in   = ST_PAD_W;
            end
         end
         ST_PAD_W, ST_PAD_H, ST_LVL_W, ST_LVL_H: begin
            if (mod_cnt_ff == MOD_LAST) begin
               mod_cnt_in = '0;
               rem_in     = '0;
               case (state_ff)
                  ST_PAD_W: begin
                     pw_in    = (up16 > DIM_W'(minw_ff)) ? up16 : DIM_W'(minw_ff);
                     w_in     = pw_in;
                     state_in = ST_PAD_H;
                  end
                  ST_PAD_H: begin
                     ph_in    = (up16 > DIM_W'(minh_ff)) ? up16 : DIM_W'(minh_ff);
                     h_in     = ph_in;
                     d_in     = depth_ff;
                     lvl_in   = '0;
                     total_in = '0;
                     state_in = ST_LVL_W;
                  end
                  ST_LVL_W: begin
                     lw_in    = (up > DEND_W'(minw_ff)) ? up : DEND_W'(minw_ff);
                     state_in = ST_LVL_H;
                  end
                  default: begin
                     lh_in    = (up > DEND_W'(minh_ff)) ? up : DEND_W'(minh_ff);
                     state_in = ST_MUL_WH;
                  end
               endcase
            end else begin
               mod_cnt_in = mod_cnt_ff + MOD_CNT_W'(1);
               rem_in     = rem_step;
            end
         end
         ST_MUL_WH: begin
            t_in     = prod[SIZE_BITS-1:0];
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            t_in     = prod[SIZE_BITS-1:0];
            state_in = ST_MUL_BPP;
         end
         ST_MUL_BPP: begin
            t_in     = prod[SIZE_BITS-1:0];
            state_in = ST_MUL_SIDES;
         end
         ST_MUL_SIDES: begin
            t_in     = prod[SIZE_BITS-1:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            total_in = total_ff + t_ff;
            w_in     = (w_ff > DIM_W'(1)) ? (w_ff >> 1) : DIM_W'(1);
            h_in     = (h_ff > DIM_W'(1)) ? (h_ff >> 1) : DIM_W'(1);
            d_in     = (d_ff > DIM_W'(1)) ? (d_ff >> 1) : DIM_W'(1);
            lvl_in   = lvl_ff + MIPS_W'(1);
            state_in = (lvl_ff == mips_ff - MIPS_W'(1)) ? ST_FINISH : ST_LVL_W;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_bytes_in = total_ff[BYTES_W-1:0];
               out_pw_in    = pw_ff;
               out_ph_in    = ph_ff;
               out_depth_in = depth_ff;
               out_mips_in  = mips_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mod_cnt_ff   <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mod_cnt_ff   <= mod_cnt_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bw_ff        <= bw_in;
      bh_ff        <= bh_in;
      depth_ff     <= depth_in;
      cube_ff      <= cube_in;
      mips_ff      <= mips_in;
      bpp_ff       <= bpp_in;
      blkw_ff      <= blkw_in;
      blkh_ff      <= blkh_in;
      minw_ff      <= minw_in;
      minh_ff      <= minh_in;
      pw_ff        <= pw_in;
      ph_ff        <= ph_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      d_ff         <= d_in;
      lw_ff        <= lw_in;
      lh_ff        <= lh_in;
      lvl_ff       <= lvl_in;
      t_ff         <= t_in;
      total_ff     <= total_in;
      out_bytes_ff <= out_bytes_in;
      out_pw_ff    <= out_pw_in;
      out_ph_ff    <= out_ph_in;
      out_depth_ff <= out_depth_in;
      out_mips_ff  <= out_mips_in;
   end

endmodule

[rtl/tmcs_checker.sv]
// port checker for the mip chain storage size block, bound to the top level
module tmcs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tmcs_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // stalled response stays
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response item changed while stalled");

   // one item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[tmcs_pkg::RSP_MIPS_LO +: tmcs_pkg::MIPS_W] != '0)
      else $error("clamped mip count is zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[tmcs_pkg::RSP_DEPTH_LO +: tmcs_pkg::DIM_W] != '0)
      else $error("clamped depth is zero");

endmodule

bind texture_mip_chain_storage_size tmcs_checker u_tmcs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
